FILE: design/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Types and codes shared by the circular buffer deque and its output queue.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int CFG_W   = 5;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_REAR  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_QUERY      = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]                req_type;
    logic signed [VALUE_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] popped_value;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
    logic [COUNT_W-1:0]        element_count;
    logic                      is_empty;
    logic                      is_full;
  } rsp_t;

endpackage

FILE: design/circular_buffer_deque.sv
// ----------------------------------------------------------------------------
// circular_buffer_deque
// Double-ended queue in a circular store with a programmable capacity.
// ----------------------------------------------------------------------------
// Channels: req (valid/ready) carries one request beat: push front, push
// rear, pop front, pop rear or query. rsp (valid/ready) returns exactly one
// beat per request with status, popped value, front/rear values, count and
// empty/full flags. cfg (valid/ready, always ready) writes the capacity;
// a write clears head, tail and count. Write it only while idle.
// Throughput: one request per cycle while the result queue has room. Each
// request is handled in a single pass: pointer/count update and store
// write, with the new front and rear entries read from the store's two
// registered read ports in the same edge. Path: an accepted request is
// captured in the result and store read registers, then written into a
// two-entry result queue, from which rsp presents it.
// Reset: head, tail and count clear, capacity returns to min(16, DEPTH).
// Store contents are not cleared; only held entries ever reach rsp.
// Stall: while rsp is stalled the result queue fills and req_ready drops
// once no room remains for a further result; nothing is lost.
// ----------------------------------------------------------------------------
module circular_buffer_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  cbd_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output cbd_pkg::rsp_t                   rsp
);

  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int CAP_RESET = (16 > DEPTH) ? DEPTH : 16;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [CW-1:0]         cap;
  logic [CW-1:0]         cap_wr;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [AW-1:0]         head;
  logic [AW-1:0]         head_next;
  logic [AW-1:0]         tail;
  logic [AW-1:0]         tail_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_front_addr;
  logic [AW-1:0]         rd_rear_addr;
  cbd_pkg::status_t      status;
  logic [DATA_WIDTH-1:0] popped;

  logic [DATA_WIDTH-1:0] front_q;
  logic [DATA_WIDTH-1:0] rear_q;
  logic                  res_valid;
  cbd_pkg::status_t      res_status;
  logic [DATA_WIDTH-1:0] res_popped;
  logic [CW-1:0]         res_count;
  logic                  res_empty;
  logic                  res_full;
  cbd_pkg::rsp_t         res;
  logic [1:0]            fifo_level;

  function automatic logic [AW-1:0] slot_before(input logic [AW-1:0] i,
                                                input logic [CW-1:0] c);
    slot_before = (i == '0) ? AW'(c - CW'(1)) : i - AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_after(input logic [AW-1:0] i,
                                               input logic [CW-1:0] c);
    logic [CW:0] inc;
    inc        = (CW+1)'(i) + (CW+1)'(1);
    slot_after = (inc >= (CW+1)'(c)) ? '0 : AW'(inc);
  endfunction

  assign cfg_ready = 1'b1;
  assign req_ready = (fifo_level == 2'd0) || ((fifo_level == 2'd1) && !res_valid) ||
                     (rsp_valid && rsp_ready);
  assign accept    = req_valid && req_ready;
  assign full      = (count >= cap);
  assign empty     = (count == '0);

  always_comb begin
    if (cfg_data == '0) begin
      cap_wr = CW'(1);
    end else if (32'(cfg_data) > DEPTH) begin
      cap_wr = CW'(DEPTH);
    end else begin
      cap_wr = CW'(cfg_data);
    end
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = tail;
    wr_data    = DATA_WIDTH'($unsigned(req.push_value));
    status     = cbd_pkg::ST_DONE;
    popped     = '0;
    unique case (req.req_type)
      cbd_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          status = cbd_pkg::ST_FULL;
        end else begin
          head_next  = slot_before(head, cap);
          wr_en      = 1'b1;
          wr_addr    = head_next;
          count_next = count + CW'(1);
        end
      end
      cbd_pkg::REQ_PUSH_REAR: begin
        if (full) begin
          status = cbd_pkg::ST_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = tail;
          tail_next  = slot_after(tail, cap);
          count_next = count + CW'(1);
        end
      end
      cbd_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          status = cbd_pkg::ST_EMPTY;
        end else begin
          popped     = front_q;
          head_next  = slot_after(head, cap);
          count_next = count - CW'(1);
        end
      end
      cbd_pkg::REQ_POP_REAR: begin
        if (empty) begin
          status = cbd_pkg::ST_EMPTY;
        end else begin
          popped     = rear_q;
          tail_next  = slot_before(tail, cap);
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_front_addr = head_next;
  assign rd_rear_addr  = slot_before(tail_next, cap);

  // store: one write port, two registered read ports with write bypass
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      front_q <= (wr_en && (wr_addr == rd_front_addr)) ? wr_data : mem[rd_front_addr];
      rear_q  <= (wr_en && (wr_addr == rd_rear_addr)) ? wr_data : mem[rd_rear_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CW'(CAP_RESET);
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap   <= cap_wr;
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end else if (accept) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
      res_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status;
      res_popped <= popped;
      res_count  <= count_next;
      res_empty  <= (count_next == '0);
      res_full   <= (count_next >= cap);
    end
  end

  always_comb begin
    res.status        = res_status;
    res.popped_value  = 32'(res_popped);
    res.front_value   = res_empty ? '0 : 32'(front_q);
    res.rear_value    = res_empty ? '0 : 32'(rear_q);
    res.element_count = cbd_pkg::COUNT_W'(res_count);
    res.is_empty      = res_empty;
    res.is_full       = res_full;
  end

  cbd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .dout      (rsp),
    .out_valid (rsp_valid),
    .out_ready (rsp_ready),
    .level     (fifo_level)
  );

endmodule

FILE: design/cbd_out_fifo.sv
// ----------------------------------------------------------------------------
// cbd_out_fifo
// Two-entry result queue between the deque core and the response channel.
// ----------------------------------------------------------------------------
module cbd_out_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cbd_pkg::rsp_t din,
  output cbd_pkg::rsp_t dout,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    level
);

  cbd_pkg::rsp_t ent [2];
  logic          wp;
  logic          rp;
  logic          pop;

  assign out_valid = (level != 2'd0);
  assign pop       = out_valid && out_ready;
  assign dout      = ent[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      unique case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule
